FILE: hw/rtl/peer_wire_message_deframer_assert.svh
// Assertion macros shared by the checkers of the deframer.
// Both sample on the rising edge of aclk and stay quiet during reset.
`ifndef PEER_WIRE_MESSAGE_DEFRAMER_ASSERT_SVH
`define PEER_WIRE_MESSAGE_DEFRAMER_ASSERT_SVH

// Property that must hold in the same cycle once its antecedent is true.
`define PWMD_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// Property whose consequent must hold in the following cycle.
`define PWMD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/pwmd_pkg.sv
package pwmd_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CURRENT_PIECE  = 3'd0,
        REG_DOWNLOADING    = 3'd1,
        REG_PIECE_SIZE     = 3'd2,
        REG_NUM_PIECES     = 3'd3,
        REG_MAX_MSG_LENGTH = 3'd4
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_PIECE_DATA = 2'd1,
        EV_HAVE       = 2'd2,
        EV_BITFIELD   = 2'd3
    } event_t;

    // Message ids
    localparam logic [7:0] MSG_CHOKE    = 8'd0;
    localparam logic [7:0] MSG_UNCHOKE  = 8'd1;
    localparam logic [7:0] MSG_HAVE     = 8'd4;
    localparam logic [7:0] MSG_BITFIELD = 8'd5;
    localparam logic [7:0] MSG_PIECE    = 8'd7;

    // Framing layout
    localparam logic [16:0] LEN_PREFIX_BYTES = 17'd4;
    localparam logic [16:0] LEN_LAST_BYTE    = 17'd3;
    localparam logic [16:0] HDR0_FIRST_K     = 17'd1;
    localparam logic [16:0] HDR0_LAST_K      = 17'd4;
    localparam logic [16:0] HDR1_LAST_K      = 17'd8;
    localparam logic [16:0] PIECE_DATA_K     = 17'd9;
    localparam logic [31:0] HAVE_MIN_LEN     = 32'd5;
    localparam logic [31:0] PIECE_HDR_LEN    = 32'd9;

    // Register reset values
    localparam logic [24:0] PIECE_SIZE_RST = 25'd262144;
    localparam logic [20:0] NUM_PIECES_RST = 21'd1;
    localparam logic [15:0] MAX_LEN_RST    = 16'd32000;

endpackage

FILE: hw/rtl/peer_wire_message_deframer.sv
// Peer-wire message deframer: takes one received stream byte (or a clear command) per
// item and returns exactly one result item per input item, carrying an optional event
// (PIECE data byte with its address in the piece, HAVE index, BITFIELD byte) plus the
// status snapshot after that byte: choke state, piece high-water position, saturating
// accepted byte count and the sticky frame error. A length prefix above
// max_message_length latches frame_error and every later stream byte is ignored until
// reset; a clear command still zeroes the piece counters. Throughput is one item per
// cycle while results are taken. An accepted item is held in the input register and
// moves to the result register once the result slot is empty or being taken; all
// parsing is done in the logic between the two registers. A stalled result holds the
// input register and drops s_ready. Write the configuration registers only while no
// item is in flight.
module peer_wire_message_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [pwmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [7:0]                          s_rx_byte,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_res,
    output logic [31:0]                         m_event_index,
    output logic [7:0]                          m_event_byte,
    output logic                                m_block_done,
    output logic                                m_choked,
    output logic [24:0]                         m_high_water,
    output logic [24:0]                         m_bytes_received,
    output logic                                m_frame_error
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] cur_piece_reg;
    logic        downloading_reg;
    logic [24:0] piece_size_reg;
    logic [20:0] num_pieces_reg;
    logic [15:0] max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_piece_reg   <= '0;
            downloading_reg <= 1'b0;
            piece_size_reg  <= pwmd_pkg::PIECE_SIZE_RST;
            num_pieces_reg  <= pwmd_pkg::NUM_PIECES_RST;
            max_len_reg     <= pwmd_pkg::MAX_LEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pwmd_pkg::REG_CURRENT_PIECE:  cur_piece_reg   <= cfg_wdata;
                pwmd_pkg::REG_DOWNLOADING:    downloading_reg <= cfg_wdata[0];
                pwmd_pkg::REG_PIECE_SIZE:     piece_size_reg  <= cfg_wdata[24:0];
                pwmd_pkg::REG_NUM_PIECES:     num_pieces_reg  <= cfg_wdata[20:0];
                pwmd_pkg::REG_MAX_MSG_LENGTH: max_len_reg     <= cfg_wdata[15:0];
                default: ;  // indexes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. Advance the
    // held item whenever the result slot is empty or being taken.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic       in_command_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_command_reg <= s_command;
            in_byte_reg    <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [31:0] length_reg,   length_next;     // length prefix of the current frame
    logic [16:0] count_reg,    count_next;      // bytes seen in the current frame
    logic [7:0]  msg_id_reg,   msg_id_next;
    logic [31:0] hdr0_reg,     hdr0_next;       // HAVE index / PIECE index
    logic [31:0] hdr1_reg,     hdr1_next;       // PIECE begin offset
    logic        accept_reg,   accept_next;     // current PIECE message is taken
    logic        choke_reg,    choke_next;
    logic [24:0] position_reg, position_next;
    logic [24:0] received_reg, received_next;
    logic        error_reg,    error_next;

    // result of the item in hand
    pwmd_pkg::event_t ev;
    logic [31:0]      ev_index;
    logic [7:0]       ev_byte;
    logic             done;

    // shared datapath terms
    logic [16:0] k;             // payload byte offset, id byte is zero
    logic        last;
    logic [7:0]  id_eff;
    logic [31:0] len_shift;
    logic [15:0] payload_len;
    logic [32:0] end_sum;
    logic        piece_ok;
    logic [21:0] np_plus7;
    logic        have_ok;
    logic [31:0] data_addr;
    logic [25:0] recv_sum;

    always_comb begin
        k         = count_reg - pwmd_pkg::LEN_PREFIX_BYTES;
        last      = ({15'd0, k} + 32'd1) == length_reg;
        id_eff    = (k == 17'd0) ? in_byte_reg : msg_id_reg;
        len_shift = {length_reg[23:0], in_byte_reg};

        hdr0_next = hdr0_reg;
        hdr1_next = hdr1_reg;
        if (k >= pwmd_pkg::HDR0_FIRST_K && k <= pwmd_pkg::HDR0_LAST_K) begin
            hdr0_next = {hdr0_reg[23:0], in_byte_reg};
        end
        if (k > pwmd_pkg::HDR0_LAST_K && k <= pwmd_pkg::HDR1_LAST_K) begin
            hdr1_next = {hdr1_reg[23:0], in_byte_reg};
        end

        // length is at most 16 bits once a frame body is being parsed
        payload_len = length_reg[15:0] - pwmd_pkg::PIECE_HDR_LEN[15:0];
        end_sum     = {1'b0, hdr1_next} + {17'd0, payload_len};
        piece_ok    = downloading_reg && (hdr0_next == cur_piece_reg) &&
                      (end_sum <= {8'd0, piece_size_reg});
        np_plus7    = {1'b0, num_pieces_reg} + 22'd7;
        have_ok     = hdr0_next[31:3] < {10'd0, np_plus7[21:3]};
        data_addr   = hdr1_reg + {15'd0, k - pwmd_pkg::PIECE_DATA_K};
        recv_sum    = {1'b0, received_reg} + {10'd0, payload_len};
    end

    always_comb begin
        length_next   = length_reg;
        count_next    = count_reg;
        msg_id_next   = msg_id_reg;
        accept_next   = accept_reg;
        choke_next    = choke_reg;
        position_next = position_reg;
        received_next = received_reg;
        error_next    = error_reg;
        ev            = pwmd_pkg::EV_NONE;
        ev_index      = '0;
        ev_byte       = '0;
        done          = 1'b0;

        priority if (in_command_reg) begin
            // clear piece progress, framing untouched
            position_next = '0;
            received_next = '0;
        end else if (error_reg) begin
            // drop the byte
        end else if (count_reg < pwmd_pkg::LEN_PREFIX_BYTES) begin
            length_next = len_shift;
            count_next  = count_reg + 17'd1;
            if (count_reg == pwmd_pkg::LEN_LAST_BYTE) begin
                priority if (len_shift == 32'd0) begin
                    count_next = '0;    // keepalive
                end else if (len_shift > {16'd0, max_len_reg}) begin
                    error_next = 1'b1;
                    count_next = '0;
                end else begin
                    count_next = pwmd_pkg::LEN_PREFIX_BYTES;
                end
            end
        end else begin
            if (k == 17'd0) begin
                msg_id_next = in_byte_reg;
            end

            if (id_eff == pwmd_pkg::MSG_BITFIELD && k != 17'd0) begin
                ev       = pwmd_pkg::EV_BITFIELD;
                ev_index = {15'd0, k - 17'd1};
                ev_byte  = in_byte_reg;
            end

            if (id_eff == pwmd_pkg::MSG_PIECE && k == pwmd_pkg::HDR1_LAST_K &&
                length_reg >= pwmd_pkg::PIECE_HDR_LEN) begin
                accept_next = piece_ok;
            end

            if (id_eff == pwmd_pkg::MSG_PIECE && k >= pwmd_pkg::PIECE_DATA_K &&
                accept_reg) begin
                ev       = pwmd_pkg::EV_PIECE_DATA;
                ev_index = data_addr;
                ev_byte  = in_byte_reg;
            end

            if (last) begin
                priority if (id_eff == pwmd_pkg::MSG_CHOKE) begin
                    choke_next = 1'b1;
                end else if (id_eff == pwmd_pkg::MSG_UNCHOKE) begin
                    choke_next = 1'b0;
                end else if (id_eff == pwmd_pkg::MSG_HAVE) begin
                    if (length_reg >= pwmd_pkg::HAVE_MIN_LEN && have_ok) begin
                        ev       = pwmd_pkg::EV_HAVE;
                        ev_index = hdr0_next;
                        ev_byte  = '0;
                    end
                end else if (id_eff == pwmd_pkg::MSG_PIECE && accept_next) begin
                    done = 1'b1;
                    if (end_sum[31:0] > {7'd0, position_reg}) begin
                        position_next = end_sum[24:0];
                    end
                    received_next = recv_sum[25] ? '1 : recv_sum[24:0];
                end else begin
                    // other ids: payload skipped
                end
                count_next  = '0;
                accept_next = 1'b0;
            end else begin
                count_next = count_reg + 17'd1;
            end
        end
    end

    // header words only move while a stream byte is parsed in a frame body
    logic body_byte;
    assign body_byte = !in_command_reg && !error_reg &&
                       (count_reg >= pwmd_pkg::LEN_PREFIX_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg   <= '0;
            count_reg    <= '0;
            msg_id_reg   <= '0;
            hdr0_reg     <= '0;
            hdr1_reg     <= '0;
            accept_reg   <= 1'b0;
            choke_reg    <= 1'b1;
            position_reg <= '0;
            received_reg <= '0;
            error_reg    <= 1'b0;
        end else if (advance) begin
            length_reg   <= length_next;
            count_reg    <= count_next;
            msg_id_reg   <= msg_id_next;
            if (body_byte) begin
                hdr0_reg <= hdr0_next;
                hdr1_reg <= hdr1_next;
            end
            accept_reg   <= accept_next;
            choke_reg    <= choke_next;
            position_reg <= position_next;
            received_reg <= received_next;
            error_reg    <= error_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold until taken
    // ------------------------------------------------------------------
    logic [1:0]  ev_reg;
    logic [31:0] ev_index_reg;
    logic [7:0]  ev_byte_reg;
    logic        done_reg;
    logic        choked_reg;
    logic [24:0] out_position_reg;
    logic [24:0] out_received_reg;
    logic        out_error_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            ev_reg           <= pwmd_pkg::EV_NONE;
            done_reg         <= 1'b0;
            choked_reg       <= 1'b1;
            out_error_reg    <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg   <= 1'b1;
                ev_reg        <= ev;
                done_reg      <= done;
                choked_reg    <= choke_next;
                out_error_reg <= error_next;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ev_index_reg     <= ev_index;
            ev_byte_reg      <= ev_byte;
            out_position_reg <= position_next;
            out_received_reg <= received_next;
        end
    end

    assign m_event_res      = ev_reg;
    assign m_event_index    = ev_index_reg;
    assign m_event_byte     = ev_byte_reg;
    assign m_block_done     = done_reg;
    assign m_choked         = choked_reg;
    assign m_high_water     = out_position_reg;
    assign m_bytes_received = out_received_reg;
    assign m_frame_error    = out_error_reg;

endmodule

FILE: hw/rtl/pwmd_checker.sv
`include "peer_wire_message_deframer_assert.svh"

module pwmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_event_res,
    input logic [31:0] m_event_index,
    input logic        m_block_done,
    input logic        m_frame_error
);

    // once raised, the frame error stays on every later item
    `PWMD_ASSERT_NEXT(a_error_sticky, m_frame_error, m_frame_error, "frame error dropped")

    // after a frame error no event and no block completion
    `PWMD_ASSERT_SAME(a_error_quiet, m_valid && m_frame_error, m_event_res == pwmd_pkg::EV_NONE && !m_block_done, "event while in frame error")

    // block completion comes only with a data byte or with no event
    `PWMD_ASSERT_SAME(a_done_event, m_valid && m_block_done, m_event_res == pwmd_pkg::EV_NONE || m_event_res == pwmd_pkg::EV_PIECE_DATA, "block done with wrong event")

    // a stalled result holds
    `PWMD_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_event_res) && $stable(m_event_index), "stalled result changed")

endmodule

bind peer_wire_message_deframer pwmd_checker u_pwmd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_res   (m_event_res),
    .m_event_index (m_event_index),
    .m_block_done  (m_block_done),
    .m_frame_error (m_frame_error)
);

FILE: bench/deframer_checker.sv
module deframer_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_command,
    input  logic [7:0]                          s_rx_byte,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_event_res,
    input  logic [31:0]                         m_event_index,
    input  logic [7:0]                          m_event_byte,
    input  logic                                m_block_done,
    input  logic                                m_choked,
    input  logic [24:0]                         m_high_water,
    input  logic [24:0]                         m_bytes_received,
    input  logic                                m_frame_error,
    output int                                  outstanding,
    output int                                  failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] COUNT_SAT = 32'h01FF_FFFF;

    typedef struct {
        pwmd_pkg::event_t ev;
        logic [31:0]      index;
        logic [7:0]       data;
        logic             done;
        logic             choked;
        logic [24:0]      position;
        logic [24:0]      count;
        logic             error;
    } deframer_result_t;

    deframer_result_t expected_q[$];
    int               results_seen;

    // register copy
    logic [31:0] cur_piece;
    logic        dl_en;
    logic [24:0] piece_sz;
    logic [20:0] npieces;
    logic [15:0] max_len;

    // parser state
    logic [31:0] len_q;
    logic [16:0] frame_pos;
    logic [7:0]  msg_id;
    logic [31:0] hdr [2];
    logic        accept_q;
    logic        choke_q;
    logic [24:0] pos_q;
    logic [24:0] cnt_q;
    logic        err_q;

    task automatic reset_parser();
        cur_piece = '0;
        dl_en     = 1'b0;
        piece_sz  = pwmd_pkg::PIECE_SIZE_RST;
        npieces   = pwmd_pkg::NUM_PIECES_RST;
        max_len   = pwmd_pkg::MAX_LEN_RST;
        len_q     = '0;
        frame_pos = '0;
        msg_id    = '0;
        hdr[0]    = '0;
        hdr[1]    = '0;
        accept_q  = 1'b0;
        choke_q   = 1'b1;
        pos_q     = '0;
        cnt_q     = '0;
        err_q     = 1'b0;
    endtask

    task automatic write_register(input logic [pwmd_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] data);
        case (idx)
            pwmd_pkg::REG_CURRENT_PIECE:  cur_piece = data;
            pwmd_pkg::REG_DOWNLOADING:    dl_en     = data[0];
            pwmd_pkg::REG_PIECE_SIZE:     piece_sz  = data[24:0];
            pwmd_pkg::REG_NUM_PIECES:     npieces   = data[20:0];
            pwmd_pkg::REG_MAX_MSG_LENGTH: max_len   = data[15:0];
            default: ;
        endcase
    endtask

    // Advance the deframer by one item and return the status it reports.
    task automatic parse_item(input logic cmd, input logic [7:0] rx,
                              output deframer_result_t r);
        logic [31:0] k;
        logic        is_last;
        logic [32:0] span;
        logic [31:0] dlen;
        logic [31:0] stop;
        logic [31:0] sum;
        r.ev    = pwmd_pkg::EV_NONE;
        r.index = '0;
        r.data  = '0;
        r.done  = 1'b0;
        if (cmd) begin
            pos_q = '0;
            cnt_q = '0;
        end else if (!err_q) begin
            if (frame_pos < pwmd_pkg::LEN_PREFIX_BYTES) begin
                len_q     = {len_q[23:0], rx};
                frame_pos = frame_pos + 17'd1;
                if (frame_pos == pwmd_pkg::LEN_PREFIX_BYTES) begin
                    if (len_q == 32'd0) begin
                        frame_pos = '0;
                    end else if (len_q > {16'd0, max_len}) begin
                        err_q     = 1'b1;
                        frame_pos = '0;
                    end
                end
            end else begin
                k       = {15'd0, frame_pos} - {15'd0, pwmd_pkg::LEN_PREFIX_BYTES};
                is_last = (k + 32'd1 == len_q);
                if (k == 32'd0) begin
                    msg_id = rx;
                end else if (k <= pwmd_pkg::HDR0_LAST_K) begin
                    hdr[0] = {hdr[0][23:0], rx};
                end else if (k <= pwmd_pkg::HDR1_LAST_K) begin
                    hdr[1] = {hdr[1][23:0], rx};
                end
                if (msg_id == pwmd_pkg::MSG_BITFIELD && k >= pwmd_pkg::HDR0_FIRST_K) begin
                    r.ev    = pwmd_pkg::EV_BITFIELD;
                    r.index = k - 32'd1;
                    r.data  = rx;
                end
                if (msg_id == pwmd_pkg::MSG_PIECE && k == pwmd_pkg::HDR1_LAST_K &&
                    len_q >= pwmd_pkg::PIECE_HDR_LEN) begin
                    span     = {1'b0, hdr[1]} + {1'b0, len_q - pwmd_pkg::PIECE_HDR_LEN};
                    accept_q = dl_en && hdr[0] == cur_piece && span <= {8'd0, piece_sz};
                end
                if (msg_id == pwmd_pkg::MSG_PIECE && k >= pwmd_pkg::PIECE_DATA_K &&
                    accept_q) begin
                    r.ev    = pwmd_pkg::EV_PIECE_DATA;
                    r.index = hdr[1] + (k - {15'd0, pwmd_pkg::PIECE_DATA_K});
                    r.data  = rx;
                end
                if (is_last) begin
                    if (msg_id == pwmd_pkg::MSG_CHOKE) begin
                        choke_q = 1'b1;
                    end else if (msg_id == pwmd_pkg::MSG_UNCHOKE) begin
                        choke_q = 1'b0;
                    end else if (msg_id == pwmd_pkg::MSG_HAVE &&
                                 len_q >= pwmd_pkg::HAVE_MIN_LEN) begin
                        if ((hdr[0] >> 3) < (({11'd0, npieces} + 32'd7) >> 3)) begin
                            r.ev    = pwmd_pkg::EV_HAVE;
                            r.index = hdr[0];
                        end
                    end else if (msg_id == pwmd_pkg::MSG_PIECE && accept_q) begin
                        dlen   = len_q - pwmd_pkg::PIECE_HDR_LEN;
                        stop   = hdr[1] + dlen;
                        r.done = 1'b1;
                        if (stop > {7'd0, pos_q})
                            pos_q = stop[24:0];
                        sum   = {7'd0, cnt_q} + dlen;
                        cnt_q = (sum > COUNT_SAT) ? COUNT_SAT[24:0] : sum[24:0];
                    end
                    frame_pos = '0;
                    accept_q  = 1'b0;
                end else begin
                    frame_pos = frame_pos + 17'd1;
                end
            end
        end
        r.choked   = choke_q;
        r.position = pos_q;
        r.count    = cnt_q;
        r.error    = err_q;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] seen);
        failures++;
        $display("deframer_checker: result %0d %s: expected 0x%0h, got 0x%0h",
                 results_seen, field, want, seen);
    endtask

    task automatic check_result();
        deframer_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("arrived with nothing pending", 32'd0, {30'd0, m_event_res});
        end else begin
            want = expected_q.pop_front();
            if (m_event_res !== want.ev)
                report_mismatch("event_res", {30'd0, want.ev}, {30'd0, m_event_res});
            if (m_event_index !== want.index)
                report_mismatch("event_index", want.index, m_event_index);
            if (m_event_byte !== want.data)
                report_mismatch("event_byte", {24'd0, want.data}, {24'd0, m_event_byte});
            if (m_block_done !== want.done)
                report_mismatch("block_done", {31'd0, want.done}, {31'd0, m_block_done});
            if (m_choked !== want.choked)
                report_mismatch("choked", {31'd0, want.choked}, {31'd0, m_choked});
            if (m_high_water !== want.position)
                report_mismatch("high_water", {7'd0, want.position},
                                {7'd0, m_high_water});
            if (m_bytes_received !== want.count)
                report_mismatch("bytes_received", {7'd0, want.count},
                                {7'd0, m_bytes_received});
            if (m_frame_error !== want.error)
                report_mismatch("frame_error", {31'd0, want.error}, {31'd0, m_frame_error});
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        deframer_result_t r;
        if (!aresetn) begin
            reset_parser();
            expected_q.delete();
            results_seen = 0;
            failures     = 0;
            outstanding <= 0;
        end else begin
            if (cfg_we)
                write_register(cfg_index, cfg_wdata);
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready) begin
                parse_item(s_command, s_rx_byte, r);
                expected_q.push_back(r);
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Ids with no dedicated handling in the deframer; their payload is skipped.
    localparam logic [7:0] MSG_INTERESTED     = 8'd2;
    localparam logic [7:0] MSG_NOT_INTERESTED = 8'd3;
    localparam logic [7:0] MSG_REQUEST        = 8'd6;
    localparam logic [7:0] MSG_CANCEL         = 8'd8;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_we;
    logic [pwmd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pwmd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_command;
    logic [7:0]                       s_rx_byte;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [1:0]                       m_event_res;
    logic [31:0]                      m_event_index;
    logic [7:0]                       m_event_byte;
    logic                             m_block_done;
    logic                             m_choked;
    logic [24:0]                      m_high_water;
    logic [24:0]                      m_bytes_received;
    logic                             m_frame_error;

    int outstanding;
    int failures;

    // Register values last written, so the generator can aim at the
    // current piece, the piece boundary and the length limit.
    logic [31:0] cfg_cur;
    logic [24:0] cfg_psize;
    logic [20:0] cfg_npieces;
    logic [15:0] cfg_maxlen;

    bit         src_idle_en;
    bit         sink_stall_en;
    int         items_sent;
    int         stall_left;
    logic [7:0] msg_buf[$];

    peer_wire_message_deframer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_event_index    (m_event_index),
        .m_event_byte     (m_event_byte),
        .m_block_done     (m_block_done),
        .m_choked         (m_choked),
        .m_high_water     (m_high_water),
        .m_bytes_received (m_bytes_received),
        .m_frame_error    (m_frame_error)
    );

    deframer_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_event_index    (m_event_index),
        .m_event_byte     (m_event_byte),
        .m_block_done     (m_block_done),
        .m_choked         (m_choked),
        .m_high_water     (m_high_water),
        .m_bytes_received (m_bytes_received),
        .m_frame_error    (m_frame_error),
        .outstanding      (outstanding),
        .failures         (failures)
    );

    always #2 aclk = ~aclk;

    // Hard stop: roughly ten times the slowest legal run of about 2100 items.
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Result side back-pressure: occasional stall bursts, long ready runs in
    // between, none at all once sink_stall_en drops.
    always @(posedge aclk) begin
        if (!aresetn || !sink_stall_en) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until the handshake; optionally idle first.
    task automatic send_item(input logic cmd, input logic [7:0] rx);
        int gap;
        if (src_idle_en && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stream byte, with a rare clear command slipped in ahead of it so that
    // clears land at every point of a frame.
    task automatic send_stream_byte(input logic [7:0] rx);
        if ($urandom_range(0, 49) == 0)
            send_item(1'b1, 8'($urandom_range(0, 255)));
        send_item(1'b0, rx);
    endtask

    // Drop valid and wait until every result is back, then let the pipe settle.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input pwmd_pkg::reg_index_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all five registers; call only with the deframer idle.
    task automatic set_config(input logic [31:0] cur, input logic dl, input logic [24:0] psize,
                              input logic [20:0] np, input logic [15:0] maxlen);
        cfg_cur     = cur;
        cfg_psize   = psize;
        cfg_npieces = np;
        cfg_maxlen  = maxlen;
        write_reg(pwmd_pkg::REG_CURRENT_PIECE, cur);
        write_reg(pwmd_pkg::REG_DOWNLOADING, {31'd0, dl});
        write_reg(pwmd_pkg::REG_PIECE_SIZE, {7'd0, psize});
        write_reg(pwmd_pkg::REG_NUM_PIECES, {11'd0, np});
        write_reg(pwmd_pkg::REG_MAX_MSG_LENGTH, {16'd0, maxlen});
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        msg_buf.push_back(w[31:24]);
        msg_buf.push_back(w[23:16]);
        msg_buf.push_back(w[15:8]);
        msg_buf.push_back(w[7:0]);
    endtask

    task automatic push_random(input int n);
        int i;
        for (i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Send one framed message: length prefix, id, then the buffered payload,
    // cut to the length or padded with random bytes. A length above the
    // current limit is swapped for a legal one so the frame error stays off.
    task automatic send_frame(input logic [31:0] len, input logic [7:0] id);
        int          i;
        logic [31:0] n;
        n = len;
        if (n > {16'd0, cfg_maxlen})
            n = $urandom_range(0, cfg_maxlen);
        for (i = 3; i >= 0; i--) send_stream_byte(n[i*8 +: 8]);
        if (n != 32'd0)
            send_stream_byte(id);
        for (i = 0; i + 1 < n; i++)
            send_stream_byte(i < msg_buf.size() ? msg_buf[i] : 8'($urandom_range(0, 255)));
        msg_buf.delete();
    endtask

    task automatic send_piece(input logic [31:0] idx, input logic [31:0] beg, input int dlen);
        push_word(idx);
        push_word(beg);
        push_random(dlen);
        send_frame(pwmd_pkg::PIECE_HDR_LEN + dlen, pwmd_pkg::MSG_PIECE);
    endtask

    task automatic send_have(input logic [31:0] idx, input logic [31:0] len);
        push_word(idx);
        send_frame(len, pwmd_pkg::MSG_HAVE);
    endtask

    // One message of random kind; mostly well-formed so that PIECE data is
    // accepted, with short, misaddressed and noise frames mixed in.
    task automatic send_random_message();
        int          pick;
        int          dlen;
        int          lim;
        logic [31:0] idx;
        logic [31:0] beg;
        logic [7:0]  id;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_frame(32'd0, pwmd_pkg::MSG_CHOKE);
        end else if (pick < 12) begin
            id = $urandom_range(0, 1) ? pwmd_pkg::MSG_UNCHOKE : pwmd_pkg::MSG_CHOKE;
            send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1, id);
        end else if (pick < 27) begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, cfg_npieces + 9);
            send_have(idx, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                                       : pwmd_pkg::HAVE_MIN_LEN);
        end else if (pick < 40) begin
            send_frame($urandom_range(1, 12), pwmd_pkg::MSG_BITFIELD);
        end else if (pick < 76) begin
            dlen = $urandom_range(0, 20);
            idx  = cfg_cur;
            if ($urandom_range(0, 5) == 0)
                idx = cfg_cur ^ (32'd1 << $urandom_range(0, 31));
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                lim = (cfg_psize > dlen) ? cfg_psize - dlen : 0;
                beg = $urandom_range(0, lim);
            end else if (pick < 9) begin
                // land on the piece end exactly or just past it
                beg = cfg_psize - dlen + $urandom_range(0, 2);
            end else begin
                beg = $urandom;
            end
            send_piece(idx, beg, dlen);
        end else if (pick < 80) begin
            push_word(cfg_cur);
            send_frame($urandom_range(1, 8), pwmd_pkg::MSG_PIECE);
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0: id = MSG_INTERESTED;
                1: id = MSG_NOT_INTERESTED;
                2: id = MSG_REQUEST;
                default: id = 8'($urandom_range(MSG_CANCEL, 255));
            endcase
            send_frame($urandom_range(1, 6), id);
        end else begin
            send_frame($urandom_range(1, 16), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int n);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < n) send_random_message();
    endtask

    initial begin
        logic [31:0] bad_len;
        int          i;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_command     = 1'b0;
        s_rx_byte     = '0;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        items_sent    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: piece 3 of 64 bytes, 20 pieces (three bitfield bytes).
        set_config(32'd3, 1'b1, 25'd64, 21'd20, pwmd_pkg::MAX_LEN_RST);
        send_frame(32'd0, pwmd_pkg::MSG_CHOKE);        // keepalive
        send_frame(32'd1, pwmd_pkg::MSG_UNCHOKE);
        send_frame(32'd3, pwmd_pkg::MSG_CHOKE);        // extra payload ignored
        send_frame(32'd1, pwmd_pkg::MSG_UNCHOKE);
        send_have(32'd23, pwmd_pkg::HAVE_MIN_LEN);     // last index in range
        send_have(32'd24, pwmd_pkg::HAVE_MIN_LEN);     // first index out of range
        send_have(32'd2, 32'd3);                       // too short
        send_have(32'd7, 32'd8);                       // longer than needed
        msg_buf.push_back(8'hFF);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'hA5);
        send_frame(32'd4, pwmd_pkg::MSG_BITFIELD);
        send_frame(32'd1, pwmd_pkg::MSG_BITFIELD);     // no payload
        send_piece(32'd3, 32'd0, 4);
        send_piece(32'd4, 32'd0, 2);                   // wrong piece
        send_piece(32'd3, 32'd60, 4);                  // ends exactly at piece size
        send_piece(32'd3, 32'd61, 4);                  // one past piece size
        push_word(32'd3);
        send_frame(32'd8, pwmd_pkg::MSG_PIECE);        // shorter than a header
        send_piece(32'd3, 32'd10, 0);                  // header only, still done
        send_piece(32'd3, 32'hFFFF_FFFE, 4);           // begin + length wraps
        send_frame(32'd4, 8'hFF);                      // unknown id
        send_item(1'b1, 8'h5A);                        // clear counters
        send_piece(32'd3, 32'd8, 2);
        // clear in the middle of a length prefix leaves framing intact
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'hC3);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h01);
        send_item(1'b0, pwmd_pkg::MSG_UNCHOKE);
        wait_quiet();

        // Random settings; drain once mid-phase to hold the sender off.
        set_config($urandom, 1'b1, 25'($urandom_range(16, 200)), 21'($urandom_range(1, 64)),
                   16'($urandom_range(30, 300)));
        run_random(220);
        wait_quiet();
        run_random(230);
        wait_quiet();

        // Upper extremes of current piece and length limit, large piece size and count.
        set_config(32'hFFFF_FFFF, 1'b1, 25'd16777216, 21'd1048576, 16'd65535);
        run_random(400);
        wait_quiet();

        // Lower extremes: downloading off, one-byte messages only.
        set_config(32'd0, 1'b0, 25'd1, 21'd1, 16'd1);
        run_random(250);
        wait_quiet();

        // Single-byte piece with downloading on.
        set_config(32'd0, 1'b1, 25'd1, 21'd1, 16'd40);
        run_random(250);
        wait_quiet();

        // Last part: no idling on either side.
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        set_config($urandom, 1'b1, 25'($urandom_range(1, 4096)),
                   21'($urandom_range(1, 2048)), 16'($urandom_range(9, 400)));
        run_random(500);
        wait_quiet();

        // Oversize length: frame error latches, later bytes are dropped,
        // clears still zero the counters.
        set_config(cfg_cur, 1'b1, cfg_psize, cfg_npieces, 16'($urandom_range(20, 100)));
        run_random(30);
        bad_len = $urandom_range(0, 1) ? {16'd0, cfg_maxlen} + 32'd1
                                       : ($urandom | 32'h0100_0000);
        for (i = 3; i >= 0; i--) send_item(1'b0, bad_len[i*8 +: 8]);
        for (i = 0; i < 40; i++)
            send_item($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));

        wait_quiet();
        if (failures == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
